[sv/tsc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_pkg
// shared types and constants of the tile signature cache
// ----------------------------------------------------------------------------
package tsc_pkg;

	localparam int SIG_W   = 64;
	localparam int AGE_W   = 32;
	localparam int SLOT_W  = 6;
	localparam int USED_W  = 7;
	localparam int POS_W   = 12;
	localparam int CAP_W   = 7;
	localparam int TILES_W = 13;
	localparam int ADDR_W  = 3;
	localparam int DATA_W  = 32;

	localparam logic [USED_W-1:0]  CACHE_ENTRIES = 7'd64;
	localparam logic [CAP_W-1:0]   CAP_RESET     = 7'd64;
	localparam logic [TILES_W-1:0] TILES_RESET   = 13'd4096;

	// register select bit of paddr
	localparam logic REG_CAPACITY = 1'b0;
	localparam logic REG_TILES    = 1'b1;

	typedef enum logic [1:0] {
		OUT_UNCHANGED = 2'd0,
		OUT_REMAP     = 2'd1,
		OUT_MISS      = 2'd2
	} outcome_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic              valid;
		logic [SLOT_W-1:0] slot;
	} map_entry_t;

	typedef struct packed {
		logic              start;
		logic              step;
		logic [SLOT_W-1:0] idx;
		logic [SLOT_W-1:0] map_slot;
	} scan_ctrl_t;

	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] match_slot;
		logic [SLOT_W-1:0] oldest_slot;
		logic [AGE_W-1:0]  map_age;
	} scan_res_t;

endpackage

[sv/tile_signature_cache_lru.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_signature_cache_lru
// fully associative tile signature cache with oldest-entry replacement
// ----------------------------------------------------------------------------
// Each tile transfer carries a map position and a 64-bit content signature and
// yields one result transfer: outcome, load_pixels, update_map and slot. One
// compare unit walks the cache entries, one per cycle, finding the first
// matching signature, the oldest entry and the age of the slot the position
// already shows. The time from a tile transfer to the next possible tile
// transfer grows with entries_used, set by the entry scan through the single
// read port of the entry memories. A finished result waits in an output
// register, so the next tile is taken while it is still stalled. After reset
// the position map is swept to empty, during which tile_stall stays high;
// register writes are taken throughout.
// ----------------------------------------------------------------------------
module tile_signature_cache_lru (
	input  logic                           clk,
	input  logic                           arst_n,
	// tile channel
	input  logic                           tile_valid,
	output logic                           tile_stall,
	input  logic [tsc_pkg::POS_W-1:0]      tile_position,
	input  logic [tsc_pkg::SIG_W-1:0]      tile_signature,
	// result channel
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic [1:0]                     outcome,
	output logic                           load_pixels,
	output logic                           update_map,
	output logic [tsc_pkg::SLOT_W-1:0]     slot,
	// register port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [tsc_pkg::ADDR_W-1:0]     paddr,
	input  logic [tsc_pkg::DATA_W-1:0]     pwdata,
	output logic [tsc_pkg::DATA_W-1:0]     prdata,
	output logic                           pready
);

	tsc_pkg::state_t state_q, state_d;

	// configuration
	logic [tsc_pkg::CAP_W-1:0]   cap_q;
	logic [tsc_pkg::TILES_W-1:0] tiles_q;

	// item and cache state
	logic [tsc_pkg::POS_W-1:0]  pos_q;
	logic [tsc_pkg::SIG_W-1:0]  sig_q;
	logic [tsc_pkg::AGE_W-1:0]  age_q;
	logic [tsc_pkg::USED_W-1:0] used_q;
	logic [tsc_pkg::SLOT_W-1:0] idx_q;

	// finished result and output register
	tsc_pkg::outcome_t          res_outcome_q;
	logic                       res_load_q;
	logic                       res_upd_q;
	logic [tsc_pkg::SLOT_W-1:0] res_slot_q;
	logic                       out_valid_q;
	tsc_pkg::outcome_t          out_outcome_q;
	logic                       out_load_q;
	logic                       out_upd_q;
	logic [tsc_pkg::SLOT_W-1:0] out_slot_q;

	logic                       tile_accept;
	logic                       out_free;
	logic                       cfg_write;
	logic                       clearing;
	logic                       scan_last;
	logic                       ent_rd_en;
	logic [tsc_pkg::SLOT_W-1:0] ent_rd_addr;
	logic [tsc_pkg::SIG_W-1:0]  ent_sig;
	logic [tsc_pkg::AGE_W-1:0]  ent_age;
	tsc_pkg::map_entry_t        map_rd;
	tsc_pkg::map_entry_t        map_wr;
	tsc_pkg::scan_ctrl_t        scan_ctrl;
	tsc_pkg::scan_res_t         scan_res;

	// decision
	logic [tsc_pkg::USED_W-1:0] eff_cap;
	logic                       cache_full;
	logic [tsc_pkg::AGE_W-1:0]  age_floor;
	logic                       slot_busy;
	logic                       reuse;
	tsc_pkg::outcome_t          dec_outcome;
	logic                       dec_load;
	logic                       dec_upd;
	logic [tsc_pkg::SLOT_W-1:0] dec_slot;
	logic                       dec_alloc;
	logic                       in_decide;

	assign tile_stall  = (state_q != tsc_pkg::ST_IDLE) || clearing;
	assign tile_accept = tile_valid && !tile_stall;
	assign out_free    = !out_valid_q || !result_stall;
	assign in_decide   = (state_q == tsc_pkg::ST_DECIDE);
	assign scan_last   = ({1'b0, idx_q} == used_q - tsc_pkg::USED_W'(1));

	// register port
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= tsc_pkg::CAP_RESET;
			tiles_q <= tsc_pkg::TILES_RESET;
		end else if (cfg_write) begin
			case (paddr[2])
				tsc_pkg::REG_CAPACITY: cap_q   <= pwdata[tsc_pkg::CAP_W-1:0];
				tsc_pkg::REG_TILES:    tiles_q <= pwdata[tsc_pkg::TILES_W-1:0];
				default:               cap_q   <= cap_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			tsc_pkg::REG_CAPACITY:
				prdata = {{(tsc_pkg::DATA_W - tsc_pkg::CAP_W){1'b0}}, cap_q};
			tsc_pkg::REG_TILES:
				prdata = {{(tsc_pkg::DATA_W - tsc_pkg::TILES_W){1'b0}}, tiles_q};
			default:
				prdata = '0;
		endcase
	end

	// entry scan: address 0 goes out with the tile transfer, then one ahead
	assign ent_rd_en   = tile_accept || (state_q == tsc_pkg::ST_SCAN);
	assign ent_rd_addr = (state_q == tsc_pkg::ST_SCAN) ?
		idx_q + tsc_pkg::SLOT_W'(1) : '0;

	assign scan_ctrl.start    = tile_accept;
	assign scan_ctrl.step     = (state_q == tsc_pkg::ST_SCAN);
	assign scan_ctrl.idx      = idx_q;
	assign scan_ctrl.map_slot = map_rd.slot;

	tsc_entry_store u_entry_store (
		.clk     (clk),
		.rd_en   (ent_rd_en),
		.rd_addr (ent_rd_addr),
		.rd_sig  (ent_sig),
		.rd_age  (ent_age),
		.sig_we  (in_decide && dec_load),
		.age_we  (in_decide),
		.wr_addr (dec_slot),
		.wr_sig  (sig_q),
		.wr_age  (age_q)
	);

	assign map_wr.valid = 1'b1;
	assign map_wr.slot  = dec_slot;

	tsc_map_store u_map_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (tile_accept),
		.rd_addr  (tile_position),
		.rd_data  (map_rd),
		.we       (in_decide && dec_upd),
		.wr_addr  (pos_q),
		.wr_data  (map_wr),
		.clearing (clearing)
	);

	tsc_scan_unit u_scan_unit (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (scan_ctrl),
		.target_sig (sig_q),
		.sig_data   (ent_sig),
		.age_data   (ent_age),
		.res        (scan_res)
	);

	// capacity clamped to 1..64
	always_comb begin
		if (cap_q == '0) begin
			eff_cap = tsc_pkg::USED_W'(1);
		end else if (cap_q > tsc_pkg::CACHE_ENTRIES) begin
			eff_cap = tsc_pkg::CACHE_ENTRIES;
		end else begin
			eff_cap = cap_q;
		end
	end

	assign cache_full = (used_q >= eff_cap);
	assign age_floor  = age_q - tsc_pkg::AGE_W'(tiles_q);
	// a slot seen within the last tiles_on_display tiles is still on screen
	assign slot_busy  = (age_q >= tsc_pkg::AGE_W'(tiles_q)) &&
		(scan_res.map_age >= age_floor);
	// an empty position with a full cache never reuses
	assign reuse      = map_rd.valid && !slot_busy;

	always_comb begin
		dec_outcome = tsc_pkg::OUT_MISS;
		dec_load    = 1'b1;
		dec_upd     = 1'b1;
		dec_slot    = scan_res.oldest_slot;
		dec_alloc   = 1'b0;
		if (scan_res.found) begin
			dec_load = 1'b0;
			dec_slot = scan_res.match_slot;
			if (map_rd.valid && map_rd.slot == scan_res.match_slot) begin
				dec_outcome = tsc_pkg::OUT_UNCHANGED;
				dec_upd     = 1'b0;
			end else begin
				dec_outcome = tsc_pkg::OUT_REMAP;
			end
		end else if (!cache_full) begin
			dec_slot  = used_q[tsc_pkg::SLOT_W-1:0];
			dec_alloc = 1'b1;
		end else if (reuse) begin
			dec_slot = map_rd.slot;
			dec_upd  = 1'b0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tsc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			tsc_pkg::ST_IDLE: begin
				if (tile_accept) begin
					state_d = (used_q == '0) ? tsc_pkg::ST_DECIDE : tsc_pkg::ST_SCAN;
				end
			end
			tsc_pkg::ST_SCAN: begin
				if (scan_last) begin
					state_d = tsc_pkg::ST_DECIDE;
				end
			end
			tsc_pkg::ST_DECIDE: begin
				state_d = tsc_pkg::ST_DONE;
			end
			tsc_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = tsc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tsc_pkg::ST_IDLE;
			end
		endcase
	end

	// age counter, fill count and scan index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_q  <= '0;
			used_q <= '0;
			idx_q  <= '0;
		end else begin
			if (tile_accept) begin
				age_q <= age_q + tsc_pkg::AGE_W'(1);
				idx_q <= '0;
			end else if (state_q == tsc_pkg::ST_SCAN && !scan_last) begin
				idx_q <= idx_q + tsc_pkg::SLOT_W'(1);
			end
			if (in_decide && dec_alloc) begin
				used_q <= used_q + tsc_pkg::USED_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tile_accept) begin
			pos_q <= tile_position;
			sig_q <= tile_signature;
		end
		if (in_decide) begin
			res_outcome_q <= dec_outcome;
			res_load_q    <= dec_load;
			res_upd_q     <= dec_upd;
			res_slot_q    <= dec_slot;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == tsc_pkg::ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tsc_pkg::ST_DONE && out_free) begin
			out_outcome_q <= res_outcome_q;
			out_load_q    <= res_load_q;
			out_upd_q     <= res_upd_q;
			out_slot_q    <= res_slot_q;
		end
	end

	assign result_valid = out_valid_q;
	assign outcome      = out_outcome_q;
	assign load_pixels  = out_load_q;
	assign update_map   = out_upd_q;
	assign slot         = out_slot_q;

`ifndef SYNTHESIS
	// no tile transfer while an item is in flight
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q != tsc_pkg::ST_IDLE |-> tile_stall)
		else $error("tile taken while busy");

	// fill count never passes the slot count
	assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= tsc_pkg::CACHE_ENTRIES)
		else $error("fill count overflow");

	// loads go with misses only
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tsc_pkg::ST_DONE |-> ((res_outcome_q == tsc_pkg::OUT_MISS) == res_load_q))
		else $error("load flag does not match outcome");

	// an unchanged tile never rewrites the map
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tsc_pkg::ST_DONE && res_outcome_q == tsc_pkg::OUT_UNCHANGED |-> !res_upd_q)
		else $error("map update on unchanged tile");

	// age counter steps once per tile transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		tile_accept |=> age_q == $past(age_q) + tsc_pkg::AGE_W'(1))
		else $error("age counter did not step");
`endif

endmodule

[sv/tsc_entry_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_entry_store
// signature and age memories, one entry per frame store slot
// ----------------------------------------------------------------------------
module tsc_entry_store (
	input  logic                          clk,
	input  logic                          rd_en,
	input  logic [tsc_pkg::SLOT_W-1:0]    rd_addr,
	output logic [tsc_pkg::SIG_W-1:0]     rd_sig,
	output logic [tsc_pkg::AGE_W-1:0]     rd_age,
	input  logic                          sig_we,
	input  logic                          age_we,
	input  logic [tsc_pkg::SLOT_W-1:0]    wr_addr,
	input  logic [tsc_pkg::SIG_W-1:0]     wr_sig,
	input  logic [tsc_pkg::AGE_W-1:0]     wr_age
);

	logic [tsc_pkg::SIG_W-1:0] sig_mem [1 << tsc_pkg::SLOT_W];
	logic [tsc_pkg::AGE_W-1:0] age_mem [1 << tsc_pkg::SLOT_W];

	always_ff @(posedge clk) begin
		if (sig_we) begin
			sig_mem[wr_addr] <= wr_sig;
		end
		if (age_we) begin
			age_mem[wr_addr] <= wr_age;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_sig <= sig_mem[rd_addr];
			rd_age <= age_mem[rd_addr];
		end
	end

endmodule

[sv/tsc_map_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_map_store
// position to slot map with a clearing sweep after reset
// ----------------------------------------------------------------------------
module tsc_map_store (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [tsc_pkg::POS_W-1:0]     rd_addr,
	output tsc_pkg::map_entry_t           rd_data,
	input  logic                          we,
	input  logic [tsc_pkg::POS_W-1:0]     wr_addr,
	input  tsc_pkg::map_entry_t           wr_data,
	output logic                          clearing
);

	tsc_pkg::map_entry_t map_mem [1 << tsc_pkg::POS_W];

	logic [tsc_pkg::POS_W-1:0] clr_addr_q;
	logic                      clearing_q;
	logic                      mem_we;
	logic [tsc_pkg::POS_W-1:0] mem_addr;
	tsc_pkg::map_entry_t       mem_data;

	// sweep writes empty entries, one per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + tsc_pkg::POS_W'(1);
			if (&clr_addr_q) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_comb begin
		if (clearing_q) begin
			mem_we   = 1'b1;
			mem_addr = clr_addr_q;
			mem_data = '0;
		end else begin
			mem_we   = we;
			mem_addr = wr_addr;
			mem_data = wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			map_mem[mem_addr] <= mem_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= map_mem[rd_addr];
		end
	end

	assign clearing = clearing_q;

endmodule

[sv/tsc_scan_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_scan_unit
// shared compare unit, one cache entry per step
// ----------------------------------------------------------------------------
module tsc_scan_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tsc_pkg::scan_ctrl_t           ctrl,
	input  logic [tsc_pkg::SIG_W-1:0]     target_sig,
	input  logic [tsc_pkg::SIG_W-1:0]     sig_data,
	input  logic [tsc_pkg::AGE_W-1:0]     age_data,
	output tsc_pkg::scan_res_t            res
);

	logic                       found_q;
	logic [tsc_pkg::SLOT_W-1:0] match_slot_q;
	logic [tsc_pkg::SLOT_W-1:0] best_slot_q;
	logic [tsc_pkg::AGE_W-1:0]  best_age_q;
	logic [tsc_pkg::AGE_W-1:0]  map_age_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctrl.start) begin
			found_q <= 1'b0;
		end else if (ctrl.step && !found_q && sig_data == target_sig) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.step) begin
			// first match wins
			if (!found_q && sig_data == target_sig) begin
				match_slot_q <= ctrl.idx;
			end
			// lowest slot on equal ages
			if (ctrl.idx == '0 || age_data < best_age_q) begin
				best_age_q  <= age_data;
				best_slot_q <= ctrl.idx;
			end
			if (ctrl.idx == ctrl.map_slot) begin
				map_age_q <= age_data;
			end
		end
	end

	assign res.found       = found_q;
	assign res.match_slot  = match_slot_q;
	assign res.oldest_slot = best_slot_q;
	assign res.map_age     = map_age_q;

endmodule
